// File: rtl/core/nsc_pkg.sv
`default_nettype none
package nsc_pkg;

  // NTP era offset from 1900-01-01 to 1970-01-01
  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;

  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
  localparam logic [14:0] DAYS_PRE_LEAP  = 15'd730;
  localparam logic [2:0]  EPOCH_WDAY     = 3'd4;

  localparam logic [10:0] YEAR_EPOCH     = 11'd1970;
  localparam logic [10:0] YEAR_LEAP_BASE = 11'd1972;

  // reciprocals: floor(x * RCP >> SHIFT) is exact over the reachable range of x
  localparam logic [24:0] DAY_RCP  = 25'd25451659;  // 1/675, x < 2^24, shift 34
  localparam logic [15:0] CYC_RCP  = 16'd45934;     // 1/1461, x < 2^15, shift 26
  localparam logic [16:0] WDAY_RCP = 17'd74899;     // 1/7, x < 2^16, shift 19
  localparam logic [17:0] HOUR_RCP = 18'd149131;    // 1/3600, x < 2^17, shift 29
  localparam logic [17:0] TMIN_RCP = 18'd139811;    // 1/60, x < 2^17, shift 23

  localparam logic [13:0] DEC_10000 = 14'd10000;
  localparam logic [6:0]  DEC_100   = 7'd100;

  // first day of month (0-based day of year) in a common year
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] st;
    case (idx)
      4'd0:    st = 9'd0;
      4'd1:    st = 9'd31;
      4'd2:    st = 9'd59;
      4'd3:    st = 9'd90;
      4'd4:    st = 9'd120;
      4'd5:    st = 9'd151;
      4'd6:    st = 9'd181;
      4'd7:    st = 9'd212;
      4'd8:    st = 9'd243;
      4'd9:    st = 9'd273;
      4'd10:   st = 9'd304;
      4'd11:   st = 9'd334;
      default: st = 9'd0;
    endcase
    return st;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ntp_seconds_to_calendar.sv
// A word accepted on start passes through stage registers s0 to s5 and the result register;
// its result strobe (out_valid) is then high for exactly one cycle.
// Throughput: one word per cycle; busy stays low and the seven-register chain never stalls.
// The receiver cannot stall; every result is presented once.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module ntp_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_ntp_seconds,
  output logic             out_valid,
  output logic             out_in_range,
  output logic [10:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday,
  output logic [24:0]      out_date_packed,
  output logic [17:0]      out_time_packed
);
  import nsc_pkg::*;

  logic accept;

  // valid chain
  logic s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, out_vld_r;

  // stage 0: Unix seconds
  logic        s0_rng_r, s0_rng_nxt;
  logic [30:0] s0_unix_r;
  logic [31:0] s0_unix_nxt;

  // stage 1: day count
  logic        s1_rng_r;
  logic [30:0] s1_unix_r;
  logic [14:0] s1_days_r, s1_days_nxt;
  logic [48:0] day_prod;

  // stage 2: second of day, leap cycle, weekday quotient
  logic        s2_rng_r, s2_lt_r, s2_lt_nxt;
  logic [16:0] s2_sod_r, s2_sod_nxt;
  logic [14:0] s2_d_r, s2_d_nxt;
  logic [9:0]  s2_dlo_r;
  logic [4:0]  s2_cyc_r, s2_cyc_nxt;
  logic [15:0] s2_wx_r, s2_wx_nxt;
  logic [11:0] s2_wq_r, s2_wq_nxt;
  logic [31:0] days_sec;
  logic [30:0] cyc_prod;
  logic [32:0] wq_prod;

  // stage 3: day in cycle, hour, minute of day, weekday
  logic        s3_rng_r, s3_lt_r;
  logic [9:0]  s3_dlo_r;
  logic [4:0]  s3_cyc_r;
  logic [10:0] s3_r_r, s3_r_nxt;
  logic [16:0] s3_sod_r;
  logic [4:0]  s3_hour_r, s3_hour_nxt;
  logic [10:0] s3_tmin_r, s3_tmin_nxt;
  logic [2:0]  s3_wday_r, s3_wday_nxt;
  logic [14:0] cyc_days, r_full;
  logic [34:0] hour_prod, tmin_prod;
  logic [15:0] wq7, wday_full;

  // stage 4: year, day of year, minute and second
  logic        s4_rng_r, s4_leap_r, s4_leap_nxt;
  logic [10:0] s4_year_r, s4_year_nxt;
  logic [8:0]  s4_doy_r, s4_doy_nxt;
  logic [4:0]  s4_hour_r;
  logic [5:0]  s4_min_r, s4_min_nxt, s4_sec_r, s4_sec_nxt;
  logic [2:0]  s4_wday_r;
  logic [10:0] year_base, hour60, min_full;
  logic [16:0] tmin60, sec_full;
  logic [9:0]  dlo_sub;
  logic [10:0] r_sub1, r_sub2, r_sub3;

  // stage 5: month and day
  logic        s5_rng_r;
  logic [10:0] s5_year_r;
  logic [3:0]  s5_month_r, s5_month_nxt;
  logic [4:0]  s5_day_r, s5_day_nxt;
  logic [4:0]  s5_hour_r;
  logic [5:0]  s5_min_r, s5_sec_r;
  logic [2:0]  s5_wday_r;
  logic [8:0]  st_sel, st_i, day_full;

  // result register
  logic        out_rng_r;
  logic [10:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r, out_hour_r;
  logic [5:0]  out_min_r, out_sec_r;
  logic [2:0]  out_wday_r;
  logic [24:0] out_date_r, out_date_nxt;
  logic [17:0] out_time_r, out_time_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 0 inputs
  assign s0_rng_nxt  = in_ntp_seconds >= NTP_UNIX_OFFSET;
  assign s0_unix_nxt = in_ntp_seconds - NTP_UNIX_OFFSET;

  // days = (unix >> 7) / 675
  assign day_prod    = 49'(s0_unix_r[30:7]) * 49'(DAY_RCP);
  assign s1_days_nxt = day_prod[48:34];

  always_comb begin
    days_sec   = 32'(s1_days_r) * 32'(SECS_PER_DAY);
    s2_sod_nxt = s1_unix_r[16:0] - days_sec[16:0];
    s2_lt_nxt  = s1_days_r < DAYS_PRE_LEAP;
    s2_d_nxt   = s1_days_r - DAYS_PRE_LEAP;
    cyc_prod   = 31'(s2_d_nxt) * 31'(CYC_RCP);
    s2_cyc_nxt = cyc_prod[30:26];
    s2_wx_nxt  = 16'(s1_days_r) + 16'(EPOCH_WDAY);
    wq_prod    = 33'(s2_wx_nxt) * 33'(WDAY_RCP);
    s2_wq_nxt  = wq_prod[30:19];
  end

  always_comb begin
    cyc_days    = 15'(s2_cyc_r) * 15'(DAYS_PER_CYCLE);
    r_full      = s2_d_r - cyc_days;
    s3_r_nxt    = r_full[10:0];
    hour_prod   = 35'(s2_sod_r) * 35'(HOUR_RCP);
    s3_hour_nxt = hour_prod[33:29];
    tmin_prod   = 35'(s2_sod_r) * 35'(TMIN_RCP);
    s3_tmin_nxt = tmin_prod[33:23];
    wq7         = 16'({s2_wq_r, 3'b000}) - 16'(s2_wq_r);
    wday_full   = s2_wx_r - wq7;
    s3_wday_nxt = wday_full[2:0];
  end

  always_comb begin
    hour60     = 11'(s3_hour_r) * 11'(SECS_PER_MIN);
    min_full   = s3_tmin_r - hour60;
    s4_min_nxt = min_full[5:0];
    tmin60     = 17'(s3_tmin_r) * 17'(SECS_PER_MIN);
    sec_full   = s3_sod_r - tmin60;
    s4_sec_nxt = sec_full[5:0];

    year_base = YEAR_LEAP_BASE + 11'({s3_cyc_r, 2'b00});
    dlo_sub   = s3_dlo_r - 10'(DAYS_PER_YEAR);
    r_sub1    = s3_r_r - 11'd366;
    r_sub2    = s3_r_r - 11'd731;
    r_sub3    = s3_r_r - 11'd1096;
    if (s3_lt_r) begin
      // 1970 and 1971 come before the first leap cycle
      s4_leap_nxt = 1'b0;
      if (s3_dlo_r >= 10'(DAYS_PER_YEAR)) begin
        s4_year_nxt = YEAR_EPOCH + 11'd1;
        s4_doy_nxt  = dlo_sub[8:0];
      end else begin
        s4_year_nxt = YEAR_EPOCH;
        s4_doy_nxt  = s3_dlo_r[8:0];
      end
    end else if (s3_r_r < 11'd366) begin
      s4_leap_nxt = 1'b1;
      s4_year_nxt = year_base;
      s4_doy_nxt  = s3_r_r[8:0];
    end else if (s3_r_r < 11'd731) begin
      s4_leap_nxt = 1'b0;
      s4_year_nxt = year_base + 11'd1;
      s4_doy_nxt  = r_sub1[8:0];
    end else if (s3_r_r < 11'd1096) begin
      s4_leap_nxt = 1'b0;
      s4_year_nxt = year_base + 11'd2;
      s4_doy_nxt  = r_sub2[8:0];
    end else begin
      s4_leap_nxt = 1'b0;
      s4_year_nxt = year_base + 11'd3;
      s4_doy_nxt  = r_sub3[8:0];
    end
  end

  // month boundaries are increasing, so the last one passed wins
  always_comb begin
    s5_month_nxt = 4'd1;
    st_sel       = 9'd0;
    st_i         = 9'd0;
    for (int i = 1; i < 12; i++) begin
      st_i = month_start(4'(i)) + 9'((s4_leap_r && i >= 2) ? 1 : 0);
      if (s4_doy_r >= st_i) begin
        s5_month_nxt = 4'(i + 1);
        st_sel       = st_i;
      end
    end
    day_full   = s4_doy_r - st_sel + 9'd1;
    s5_day_nxt = day_full[4:0];
  end

  assign out_date_nxt = 25'(s5_year_r) * 25'(DEC_10000) + 25'(s5_month_r) * 25'(DEC_100)
                        + 25'(s5_day_r);
  assign out_time_nxt = 18'(s5_hour_r) * 18'(DEC_10000) + 18'(s5_min_r) * 18'(DEC_100)
                        + 18'(s5_sec_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s0_vld_r  <= accept;
      s1_vld_r  <= s0_vld_r;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      out_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_rng_r  <= s0_rng_nxt;
    s0_unix_r <= s0_unix_nxt[30:0];

    s1_rng_r  <= s0_rng_r;
    s1_unix_r <= s0_unix_r;
    s1_days_r <= s1_days_nxt;

    s2_rng_r <= s1_rng_r;
    s2_lt_r  <= s2_lt_nxt;
    s2_sod_r <= s2_sod_nxt;
    s2_d_r   <= s2_d_nxt;
    s2_dlo_r <= s1_days_r[9:0];
    s2_cyc_r <= s2_cyc_nxt;
    s2_wx_r  <= s2_wx_nxt;
    s2_wq_r  <= s2_wq_nxt;

    s3_rng_r  <= s2_rng_r;
    s3_lt_r   <= s2_lt_r;
    s3_dlo_r  <= s2_dlo_r;
    s3_cyc_r  <= s2_cyc_r;
    s3_r_r    <= s3_r_nxt;
    s3_sod_r  <= s2_sod_r;
    s3_hour_r <= s3_hour_nxt;
    s3_tmin_r <= s3_tmin_nxt;
    s3_wday_r <= s3_wday_nxt;

    s4_rng_r  <= s3_rng_r;
    s4_leap_r <= s4_leap_nxt;
    s4_year_r <= s4_year_nxt;
    s4_doy_r  <= s4_doy_nxt;
    s4_hour_r <= s3_hour_r;
    s4_min_r  <= s4_min_nxt;
    s4_sec_r  <= s4_sec_nxt;
    s4_wday_r <= s3_wday_r;

    s5_rng_r   <= s4_rng_r;
    s5_year_r  <= s4_year_r;
    s5_month_r <= s5_month_nxt;
    s5_day_r   <= s5_day_nxt;
    s5_hour_r  <= s4_hour_r;
    s5_min_r   <= s4_min_r;
    s5_sec_r   <= s4_sec_r;
    s5_wday_r  <= s4_wday_r;

    // before 1970 every field reads zero
    out_rng_r   <= s5_rng_r;
    out_year_r  <= s5_rng_r ? s5_year_r : '0;
    out_month_r <= s5_rng_r ? s5_month_r : '0;
    out_day_r   <= s5_rng_r ? s5_day_r : '0;
    out_hour_r  <= s5_rng_r ? s5_hour_r : '0;
    out_min_r   <= s5_rng_r ? s5_min_r : '0;
    out_sec_r   <= s5_rng_r ? s5_sec_r : '0;
    out_wday_r  <= s5_rng_r ? s5_wday_r : '0;
    out_date_r  <= s5_rng_r ? out_date_nxt : '0;
    out_time_r  <= s5_rng_r ? out_time_nxt : '0;
  end

  assign out_valid       = out_vld_r;
  assign out_in_range    = out_rng_r;
  assign out_year        = out_year_r;
  assign out_month       = out_month_r;
  assign out_day         = out_day_r;
  assign out_hour        = out_hour_r;
  assign out_minute      = out_min_r;
  assign out_second      = out_sec_r;
  assign out_weekday     = out_wday_r;
  assign out_date_packed = out_date_r;
  assign out_time_packed = out_time_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 7))
    else $error("result word without a matching accepted word");

  a_zero_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_year == 11'd0 && out_date_packed == 25'd0
      && out_time_packed == 18'd0 && out_weekday == 3'd0)
    else $error("out-of-range word carries nonzero fields");

  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |-> out_month >= 4'd1 && out_month <= 4'd12
      && out_day >= 5'd1 && out_hour < 5'd24 && out_minute < 6'd60
      && out_second < 6'd60 && out_weekday < 3'd7)
    else $error("calendar field out of its range");

endmodule
`default_nettype wire

// File: dv/ntp_seconds_to_calendar_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module ntp_seconds_to_calendar_tb;
  import nsc_pkg::NTP_UNIX_OFFSET;

  typedef struct {
    logic [31:0] ntp;
    logic        in_range;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [24:0] date_packed;
    logic [17:0] time_packed;
  } calendar_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_ntp_seconds = '0;
  logic        busy;
  logic        out_valid;
  logic        out_in_range;
  logic [10:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;
  logic [24:0] out_date_packed;
  logic [17:0] out_time_packed;

  calendar_t   pending_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned no_gap_left = 0;
  int unsigned month_first[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  ntp_seconds_to_calendar uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_ntp_seconds (in_ntp_seconds),
    .out_valid      (out_valid),
    .out_in_range   (out_in_range),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_hour       (out_hour),
    .out_minute     (out_minute),
    .out_second     (out_second),
    .out_weekday    (out_weekday),
    .out_date_packed(out_date_packed),
    .out_time_packed(out_time_packed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("ntp_seconds_to_calendar_tb failed");
    $finish;
  end

  function automatic calendar_t ntp_to_calendar(input logic [31:0] ntp);
    calendar_t   c;
    int unsigned secs, days, sod, yr, doy, mon, dd, r, d, hh, mm, ss;
    bit          leap;
    c = '{default: '0};
    c.ntp = ntp;
    if (ntp < NTP_UNIX_OFFSET) return c;
    secs = ntp - NTP_UNIX_OFFSET;
    days = secs / 86400;
    sod  = secs % 86400;
    // 1970 and 1971 come before the first four-year cycle
    if (days < 730) begin
      yr   = 1970 + days / 365;
      doy  = days % 365;
      leap = 1'b0;
    end else begin
      d  = days - 730;
      r  = d % 1461;
      yr = 1972 + 4 * (d / 1461);
      if (r < 366) begin
        leap = 1'b1;
        doy  = r;
      end else begin
        r    = r - 366;
        yr   = yr + 1 + r / 365;
        doy  = r % 365;
        leap = 1'b0;
      end
    end
    mon = 1;
    for (int i = 1; i < 12; i++) begin
      if (doy >= month_first[i] + ((leap && i >= 2) ? 1 : 0)) mon = i + 1;
    end
    dd = doy - (month_first[mon-1] + ((leap && mon >= 3) ? 1 : 0)) + 1;
    hh = sod / 3600;
    mm = (sod % 3600) / 60;
    ss = sod % 60;
    c.in_range    = 1'b1;
    c.year        = yr[10:0];
    c.month       = mon[3:0];
    c.day         = dd[4:0];
    c.hour        = hh[4:0];
    c.minute      = mm[5:0];
    c.second      = ss[5:0];
    c.weekday     = 3'((days + 4) % 7);
    c.date_packed = 25'(yr * 10000 + mon * 100 + dd);
    c.time_packed = 18'(hh * 10000 + mm * 100 + ss);
    return c;
  endfunction

  // seconds count for a given day since 1970-01-01 and second of day, clipped to 32 bits
  function automatic logic [31:0] ntp_at(input int unsigned days, input int unsigned sod);
    longint unsigned v;
    v = longint'(NTP_UNIX_OFFSET) + longint'(days) * 86400 + longint'(sod);
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(99);
    if (no_gap_left > 0) return 0;
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned p, sod;
    p = $urandom_range(99);
    if (p < 20) return $urandom;
    if (p < 30) return $urandom_range(NTP_UNIX_OFFSET - 1, 0);
    if (p < 75) return $urandom_range(32'hFFFF_FFFF, NTP_UNIX_OFFSET);
    // land near a day boundary
    case ($urandom_range(3))
      0:       sod = 0;
      1:       sod = 86399;
      2:       sod = $urandom_range(5);
      default: sod = 86399 - $urandom_range(5);
    endcase
    return ntp_at($urandom_range(24855), sod);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want,
                                 input logic [31:0] ntp);
    if (mismatch_count < 100)
      $display("%0t: %s got %0d expected %0d (ntp seconds %0d)", $time, what, got, want, ntp);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected word, year", out_year, 0, 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_in_range !== want.in_range)
          report_mismatch("in_range", out_in_range, want.in_range, want.ntp);
        if (out_year !== want.year) report_mismatch("year", out_year, want.year, want.ntp);
        if (out_month !== want.month) report_mismatch("month", out_month, want.month, want.ntp);
        if (out_day !== want.day) report_mismatch("day", out_day, want.day, want.ntp);
        if (out_hour !== want.hour) report_mismatch("hour", out_hour, want.hour, want.ntp);
        if (out_minute !== want.minute)
          report_mismatch("minute", out_minute, want.minute, want.ntp);
        if (out_second !== want.second)
          report_mismatch("second", out_second, want.second, want.ntp);
        if (out_weekday !== want.weekday)
          report_mismatch("weekday", out_weekday, want.weekday, want.ntp);
        if (out_date_packed !== want.date_packed)
          report_mismatch("date_packed", out_date_packed, want.date_packed, want.ntp);
        if (out_time_packed !== want.time_packed)
          report_mismatch("time_packed", out_time_packed, want.time_packed, want.ntp);
      end
    end
  end

  task automatic send_word(input logic [31:0] secs);
    int unsigned gap;
    start          <= 1'b1;
    in_ntp_seconds <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dates.push_back(ntp_to_calendar(secs));
    if (no_gap_left > 0) no_gap_left--;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] words[$];
    words = '{32'd0, 32'hFFFF_FFFF, NTP_UNIX_OFFSET - 1, NTP_UNIX_OFFSET,
              ntp_at(364, 86399), ntp_at(365, 0), ntp_at(729, 86399), ntp_at(730, 0),
              ntp_at(788, 43200), ntp_at(789, 0), ntp_at(789, 86399), ntp_at(790, 0),
              ntp_at(1095, 86399), ntp_at(1096, 0), ntp_at(1155, 1),
              ntp_at(11016, 45296), ntp_at(11322, 86399), ntp_at(11323, 0),
              32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'hD555_5555};
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_random_idle(input int unsigned count);
    repeat (count) begin
      if (no_gap_left == 0 && $urandom_range(99) < 3) no_gap_left = $urandom_range(40, 10);
      send_word(pick_word());
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_gap_left = count;
    repeat (count) send_word(pick_word());
    no_gap_left = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_idle(400);
    // hold the sender off until the pipeline has emptied
    wait_drained();
    test_back_to_back(150);
    test_random_idle(300);
    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ntp_seconds_to_calendar_tb passed");
    end else begin
      $display("ntp_seconds_to_calendar_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: ntp_seconds_to_calendar.f
rtl/core/nsc_pkg.sv
rtl/core/ntp_seconds_to_calendar.sv
dv/ntp_seconds_to_calendar_tb.sv
